>>> rtl/ordered_list_engine_top_defines.svh
// Assertion macros for the bound checker ole_checker.
`ifndef ORDERED_LIST_ENGINE_TOP_DEFINES_SVH
`define ORDERED_LIST_ENGINE_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its trigger.
`define OLE_CHK_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its trigger.
`define OLE_CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/ole_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ole_pkg;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_SEARCH = 2'd2,
		ACT_NOP    = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// What a registered read is for.
	typedef enum logic [1:0] {
		RK_UP  = 2'd0,
		RK_DN  = 2'd1,
		RK_CMP = 2'd2,
		RK_MID = 2'd3
	} rd_kind_t;

	typedef enum logic [2:0] {
		IDX_HOLD  = 3'd0,
		IDX_LAST  = 3'd1,
		IDX_AFTER = 3'd2,
		IDX_ZERO  = 3'd3,
		IDX_DEC   = 3'd4,
		IDX_INC   = 3'd5
	} idx_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_INS_RD,
		S_INS_DRAIN,
		S_INS_PUT,
		S_DEL_RD,
		S_DEL_DRAIN,
		S_SRCH_RD,
		S_SRCH_DRAIN,
		S_MID,
		S_FIN
	} state_t;

	typedef struct packed {
		logic     load;
		logic     rd_en;
		rd_kind_t rd_kind;
		idx_op_t  idx_op;
		logic     put;
		logic     cnt_inc;
		logic     cnt_dec;
		logic     set_full;
		logic     set_empty;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		act_t act;
		logic full;
		logic empty;
		logic ins_tail;
		logic del_tail;
		logic idx_eq_at;
		logic idx_eq_last;
	} sts_t;

endpackage

`default_nettype wire

>>> rtl/ole_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module ole_datapath
	import ole_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	input  wire logic [1:0]  action,
	input  wire logic [6:0]  position,
	input  wire logic [31:0] value,
	output logic             found,
	output logic [6:0]       list_length,
	output logic [31:0]      middle_value,
	output logic             middle_valid,
	output logic [1:0]       status
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > 7) ? CW : 7;

	logic [31:0]   mem [CAPACITY];
	logic [31:0]   rdata_q;
	logic          rv_q;
	rd_kind_t      rkind_q;
	logic [AW-1:0] wa_q;

	act_t          act_q;
	logic [31:0]   key_q;
	logic [CW-1:0] at_q;
	logic [AW-1:0] idx_q;
	logic [CW-1:0] cnt_q;
	logic          found_q;
	logic [1:0]    status_q;

	logic [XW-1:0] pos_x;
	logic [XW-1:0] cnt_x;
	logic [XW-1:0] last_x;
	logic [XW-1:0] ins_at;
	logic [XW-1:0] del_at;
	logic [CW-1:0] cnt_m1;
	logic [AW-1:0] mid_addr;
	logic [AW-1:0] raddr;

	assign pos_x    = XW'(position);
	assign cnt_x    = XW'(cnt_q);
	assign last_x   = cnt_x - XW'(1);
	assign ins_at   = (pos_x < cnt_x) ? pos_x : cnt_x;
	assign del_at   = (pos_x < last_x) ? pos_x : last_x;
	assign cnt_m1   = cnt_q - CW'(1);
	assign mid_addr = AW'(cnt_m1 >> 1);
	assign raddr    = (cmd.rd_kind == RK_MID) ? mid_addr : idx_q;

	assign sts.act         = act_q;
	assign sts.full        = (cnt_q == CW'(CAPACITY));
	assign sts.empty       = (cnt_q == '0);
	assign sts.ins_tail    = (at_q == cnt_q);
	assign sts.del_tail    = (at_q == cnt_m1);
	assign sts.idx_eq_at   = (CW'(idx_q) == at_q);
	assign sts.idx_eq_last = (CW'(idx_q) == cnt_m1);

	// Entry store: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata_q <= mem[raddr];
		end
		if (rv_q && (rkind_q != RK_CMP)) begin
			mem[wa_q] <= rdata_q;
		end else if (cmd.put) begin
			mem[AW'(at_q)] <= key_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rkind_q <= cmd.rd_kind;
			wa_q    <= (cmd.rd_kind == RK_UP) ? (idx_q + AW'(1)) : (idx_q - AW'(1));
		end
		if (cmd.load) begin
			key_q <= value;
			at_q  <= (act_t'(action) == ACT_DELETE) ? CW'(del_at) : CW'(ins_at);
		end
		case (cmd.idx_op)
			IDX_LAST:  idx_q <= AW'(cnt_m1);
			IDX_AFTER: idx_q <= AW'(at_q + CW'(1));
			IDX_ZERO:  idx_q <= '0;
			IDX_DEC:   idx_q <= idx_q - AW'(1);
			IDX_INC:   idx_q <= idx_q + AW'(1);
			default:   idx_q <= idx_q;
		endcase
		if (cmd.out_load) begin
			found        <= found_q;
			list_length  <= cnt_x[6:0];
			middle_value <= sts.empty ? '0 : rdata_q;
			middle_valid <= !sts.empty;
			status       <= status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q     <= 1'b0;
			act_q    <= ACT_NOP;
			cnt_q    <= '0;
			found_q  <= 1'b0;
			status_q <= ST_DONE;
		end else begin
			rv_q <= cmd.rd_en && (cmd.rd_kind != RK_MID);
			if (cmd.load) begin
				act_q    <= act_t'(action);
				found_q  <= 1'b0;
				status_q <= ST_DONE;
			end else if (rv_q && (rkind_q == RK_CMP) && (rdata_q == key_q)) begin
				found_q <= 1'b1;
			end
			if (cmd.set_full) begin
				status_q <= ST_FULL;
			end else if (cmd.set_empty) begin
				status_q <= ST_EMPTY;
			end
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_m1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/ole_controller.sv
`timescale 1ns / 1ps
`default_nettype none

module ole_controller
	import ole_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   out_busy;

	assign out_busy  = rsp_valid && rsp_stall;
	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_nxt = S_EXEC;
			end
			S_EXEC: begin
				case (sts.act)
					ACT_INSERT: begin
						if (sts.full || sts.ins_tail) state_nxt = S_MID;
						else state_nxt = S_INS_RD;
					end
					ACT_DELETE: begin
						if (sts.empty || sts.del_tail) state_nxt = S_MID;
						else state_nxt = S_DEL_RD;
					end
					ACT_SEARCH: begin
						if (sts.empty) state_nxt = S_MID;
						else state_nxt = S_SRCH_RD;
					end
					default: state_nxt = S_MID;
				endcase
			end
			S_INS_RD: begin
				if (sts.idx_eq_at) state_nxt = S_INS_DRAIN;
			end
			S_INS_DRAIN:  state_nxt = S_INS_PUT;
			S_INS_PUT:    state_nxt = S_MID;
			S_DEL_RD: begin
				if (sts.idx_eq_last) state_nxt = S_DEL_DRAIN;
			end
			S_DEL_DRAIN:  state_nxt = S_MID;
			S_SRCH_RD: begin
				if (sts.idx_eq_last) state_nxt = S_SRCH_DRAIN;
			end
			S_SRCH_DRAIN: state_nxt = S_MID;
			S_MID:        state_nxt = S_FIN;
			S_FIN: begin
				if (!out_busy) state_nxt = S_IDLE;
			end
			default:      state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.rd_kind = RK_MID;
		cmd.idx_op  = IDX_HOLD;
		case (state_q)
			S_IDLE: begin
				cmd.load = req_valid;
			end
			S_EXEC: begin
				case (sts.act)
					ACT_INSERT: begin
						if (sts.full) begin
							cmd.set_full = 1'b1;
						end else if (sts.ins_tail) begin
							cmd.put     = 1'b1;
							cmd.cnt_inc = 1'b1;
						end else begin
							cmd.idx_op = IDX_LAST;
						end
					end
					ACT_DELETE: begin
						if (sts.empty) begin
							cmd.set_empty = 1'b1;
						end else if (sts.del_tail) begin
							cmd.cnt_dec = 1'b1;
						end else begin
							cmd.idx_op = IDX_AFTER;
						end
					end
					ACT_SEARCH: begin
						if (!sts.empty) cmd.idx_op = IDX_ZERO;
					end
					default: ;
				endcase
			end
			S_INS_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_kind = RK_UP;
				if (!sts.idx_eq_at) cmd.idx_op = IDX_DEC;
			end
			S_INS_PUT: begin
				cmd.put     = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			S_DEL_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_kind = RK_DN;
				if (!sts.idx_eq_last) cmd.idx_op = IDX_INC;
			end
			S_DEL_DRAIN: begin
				cmd.cnt_dec = 1'b1;
			end
			S_SRCH_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_kind = RK_CMP;
				if (!sts.idx_eq_last) cmd.idx_op = IDX_INC;
			end
			S_MID: begin
				cmd.rd_en = !sts.empty;
			end
			S_FIN: begin
				cmd.out_load = !out_busy;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rsp_valid <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/ordered_list_engine_top.sv
// Ordered list engine: a bounded list of signed 32-bit entries in list order.
// Request channel (req_valid / req_stall): action, position, value. Insert
// puts value at min(position, length); delete removes the entry at
// min(position, length-1); search reports whether any entry equals value.
// Response channel (rsp_valid / rsp_stall): found, list_length, middle_value
// (entry at (length-1)/2), middle_valid and status, one response per request.
// A request is taken only while the engine is idle; one request is in work
// at a time. The shift and search walk the entry store one entry per cycle
// through its single write port and single registered read port; that walk
// sets the rate. Inserts and deletes at the tail, full inserts, empty deletes,
// empty searches and no-ops skip the walk.
// The response sits in an output register, so the next request is accepted
// while it waits; a stalled response holds, and the engine waits only when a
// new response is ready and the old one is still stalled.
// Reset clears the length, the control state and rsp_valid; entry contents
// are not cleared and no clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_engine_top
	import ole_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [1:0]  action,
	input  wire logic [6:0]  position,
	input  wire logic [31:0] value,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic             found,
	output logic [6:0]       list_length,
	output logic [31:0]      middle_value,
	output logic             middle_valid,
	output logic [1:0]       status
);

	// Commands from the sequencer, status back from the datapath.
	cmd_t cmd;
	sts_t sts;

	ole_controller u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Entry store, length, index walk and the response register.
	ole_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.action       (action),
		.position     (position),
		.value        (value),
		.found        (found),
		.list_length  (list_length),
		.middle_value (middle_value),
		.middle_valid (middle_valid),
		.status       (status)
	);

endmodule

`default_nettype wire

>>> rtl/ole_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "ordered_list_engine_top_defines.svh"

module ole_checker
	import ole_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_valid,
	input wire logic       req_stall,
	input wire logic       rsp_valid,
	input wire logic       rsp_stall,
	input wire logic       found,
	input wire logic [6:0] list_length,
	input wire logic       middle_valid,
	input wire logic [1:0] status
);

	// A stalled response stays up.
	`OLE_CHK_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid, "response dropped while stalled")

	// Only one request in work: stall right after acceptance.
	`OLE_CHK_NEXT(a_one_inflight, clk, arst_n, req_valid && !req_stall, req_stall, "second request accepted while busy")

	// Middle is valid exactly when the list holds entries.
	`OLE_CHK_NOW(a_mid_valid, clk, arst_n, rsp_valid, (CAPACITY > 127) || (middle_valid == (list_length != 7'd0)), "middle_valid disagrees with length")

	// A dropped insert or ignored delete never reports a hit.
	`OLE_CHK_NOW(a_no_hit_on_error, clk, arst_n, rsp_valid && (status != ST_DONE), !found, "hit reported on a failed request")

endmodule

bind ordered_list_engine_top ole_checker #(.CAPACITY(CAPACITY)) u_ole_checker (.*);

`default_nettype wire

>>> sim/ordered_list_checker.sv
`timescale 1ns / 1ps

module ordered_list_checker
	import ole_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	input  wire logic        req_stall,
	input  wire logic [1:0]  action,
	input  wire logic [6:0]  position,
	input  wire logic [31:0] value,
	input  wire logic        rsp_valid,
	input  wire logic        rsp_stall,
	input  wire logic        found,
	input  wire logic [6:0]  list_length,
	input  wire logic [31:0] middle_value,
	input  wire logic        middle_valid,
	input  wire logic [1:0]  status,
	output int               fail_count,
	output int               pending_replies
);

	typedef struct {
		logic        hit;
		logic [6:0]  length;
		logic [31:0] mid;
		logic        mid_valid;
		status_t     st;
	} list_reply_t;

	logic [31:0] list_entries [CAPACITY];
	int          list_count;
	list_reply_t expected_replies [$];

	// Apply one request to the shadow list and return the reply it should produce.
	function automatic list_reply_t apply_to_list(act_t act, logic [6:0] pos, logic [31:0] val);
		list_reply_t r;
		int          at;
		int          last;
		int          i;
		r.hit = 1'b0;
		r.st  = ST_DONE;
		case (act)
			ACT_INSERT: begin
				if (list_count >= CAPACITY) begin
					r.st = ST_FULL;
				end else begin
					at = (int'(pos) < list_count) ? int'(pos) : list_count;
					for (i = list_count; i > at; i--)
						list_entries[i] = list_entries[i - 1];
					list_entries[at] = val;
					list_count++;
				end
			end
			ACT_DELETE: begin
				if (list_count == 0) begin
					r.st = ST_EMPTY;
				end else begin
					last = list_count - 1;
					at   = (int'(pos) < last) ? int'(pos) : last;
					for (i = at; i < last; i++)
						list_entries[i] = list_entries[i + 1];
					list_count = last;
				end
			end
			ACT_SEARCH: begin
				for (i = 0; i < list_count; i++)
					if (list_entries[i] == val)
						r.hit = 1'b1;
			end
			default: begin
			end
		endcase
		r.length = list_count[6:0];
		if (list_count > 0) begin
			r.mid       = list_entries[(list_count - 1) / 2];
			r.mid_valid = 1'b1;
		end else begin
			r.mid       = '0;
			r.mid_valid = 1'b0;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_reply_t exp;
		if (!arst_n) begin
			list_count = 0;
			expected_replies.delete();
			fail_count = 0;
			pending_replies = 0;
		end else begin
			// Compare the reply first: a request taken on this edge cannot answer yet.
			if (rsp_valid && !rsp_stall) begin
				if (expected_replies.size() == 0) begin
					$error("reply with no request outstanding");
					fail_count++;
				end else begin
					exp = expected_replies.pop_front();
					if (found !== exp.hit) begin
						$error("found: expected %0d, actual %0d", exp.hit, found);
						fail_count++;
					end
					if (list_length !== exp.length) begin
						$error("list_length: expected %0d, actual %0d", exp.length, list_length);
						fail_count++;
					end
					if (middle_value !== exp.mid) begin
						$error("middle_value: expected %0d, actual %0d",
							$signed(exp.mid), $signed(middle_value));
						fail_count++;
					end
					if (middle_valid !== exp.mid_valid) begin
						$error("middle_valid: expected %0d, actual %0d",
							exp.mid_valid, middle_valid);
						fail_count++;
					end
					if (status !== exp.st) begin
						$error("status: expected %0d, actual %0d", exp.st, status);
						fail_count++;
					end
				end
			end
			if (req_valid && !req_stall)
				expected_replies.push_back(apply_to_list(act_t'(action), position, value));
			pending_replies = expected_replies.size();
		end
	end

endmodule

>>> sim/ordered_list_engine_top_tb.sv
`timescale 1ns / 1ps

module ordered_list_engine_top_tb;
	import ole_pkg::*;

	localparam int CAPACITY       = 64;
	localparam int SEG_REQUESTS   = 116;	// random requests per segment
	localparam int HOLD_CYCLES    = 400;	// long receiver hold-off
	localparam int WATCHDOG_LIMIT = 4000;	// cycles with no handshake at all
	localparam int DRAIN_CYCLES   = 100;	// settle time after the last reply

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic [1:0]  action;
	logic [6:0]  position;
	logic [31:0] value;
	logic        rsp_valid;
	logic        rsp_stall;
	logic        found;
	logic [6:0]  list_length;
	logic [31:0] middle_value;
	logic        middle_valid;
	logic [1:0]  status;

	int fail_count;
	int pending_replies;

	// Idle and stall rates in percent, set per segment by the stimulus.
	int snd_idle_pct;
	int rcv_stall_pct;

	// Hold-off handshake between stimulus and receiver: each side owns one counter.
	int hold_requests;
	int holds_served;

	// Recently inserted values, reused as search keys so searches actually hit.
	logic [31:0] recent_values [$];

	ordered_list_engine_top #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.action(action),
		.position(position),
		.value(value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.found(found),
		.list_length(list_length),
		.middle_value(middle_value),
		.middle_valid(middle_valid),
		.status(status)
	);

	ordered_list_checker #(
		.CAPACITY(CAPACITY)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.action(action),
		.position(position),
		.value(value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.found(found),
		.list_length(list_length),
		.middle_value(middle_value),
		.middle_valid(middle_valid),
		.status(status),
		.fail_count(fail_count),
		.pending_replies(pending_replies)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Extreme and corner data values: sign boundaries, zero, all ones, a mixed bit pattern.
	function automatic logic [31:0] corner_value(int k);
		case (k)
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			4: return 32'h0000_0001;
			5: return 32'h8000_0001;
			6: return 32'h7FFF_FFFE;
			default: return 32'h5A5A_5A5A;
		endcase
	endfunction

	// Offer one request; idle the channel first at the current rate, then hold
	// the payload until the engine takes it.
	task automatic send_request(act_t act, logic [6:0] pos, logic [31:0] val);
		while ($urandom_range(99) < snd_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		action    <= act;
		position  <= pos;
		value     <= val;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// Build one random request; the insert and delete shares steer the length
	// toward full or toward empty.
	task automatic send_random_request(int ins_pct, int del_pct);
		act_t        act;
		logic [6:0]  pos;
		logic [31:0] val;
		int          r;
		r = $urandom_range(99);
		if (r < ins_pct)
			act = ACT_INSERT;
		else if (r < ins_pct + del_pct)
			act = ACT_DELETE;
		else if (r < 98)
			act = ACT_SEARCH;
		else
			act = ACT_NOP;

		// Favor head and tail, which are the interesting ends of the shift.
		r = $urandom_range(99);
		if (r < 15)
			pos = 7'd0;
		else if (r < 30)
			pos = 7'($urandom_range(60, 64));
		else
			pos = 7'($urandom_range(0, 64));

		r = $urandom_range(99);
		val = $urandom;
		if (act == ACT_INSERT) begin
			if (r < 20)
				val = corner_value($urandom_range(0, 7));
			recent_values.push_back(val);
			if (recent_values.size() > 16)
				void'(recent_values.pop_front());
		end else if (act == ACT_SEARCH) begin
			if (r < 50 && recent_values.size() > 0)
				val = recent_values[$urandom_range(0, recent_values.size() - 1)];
			else if (r < 65)
				val = corner_value($urandom_range(0, 7));
		end
		send_request(act, pos, val);
	endtask

	// Receiver: stall at the current rate, or hold off for a long stretch on request.
	initial begin
		int hold_left;
		hold_left    = 0;
		holds_served = 0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && holds_served != hold_requests) begin
				hold_left = HOLD_CYCLES;
				holds_served++;
			end
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else begin
				rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
			end
		end
	end

	// Watchdog: end the run when neither channel moves for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("ordered_list_engine_top_tb: FAIL");
		$finish;
	end

	initial begin
		int seg;
		int n;
		int ins_pct;
		int del_pct;

		arst_n        = 1'b0;
		req_valid     = 1'b0;
		action        = ACT_NOP;
		position      = '0;
		value         = '0;
		snd_idle_pct  = 0;
		rcv_stall_pct = 0;
		hold_requests = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-list cases, head and tail inserts, searches, no-op,
		// deletes at tail, head and middle, then drain and delete on empty again.
		send_request(ACT_DELETE, 7'd0, 32'h0);
		send_request(ACT_SEARCH, 7'd0, 32'h0);
		send_request(ACT_NOP, 7'd64, 32'hFFFF_FFFF);
		send_request(ACT_INSERT, 7'd0, 32'h7FFF_FFFF);
		send_request(ACT_INSERT, 7'd64, 32'h8000_0000);
		send_request(ACT_INSERT, 7'd0, 32'hFFFF_FFFF);
		send_request(ACT_INSERT, 7'd1, 32'h0000_0000);
		send_request(ACT_INSERT, 7'd2, 32'h0000_0001);
		send_request(ACT_SEARCH, 7'd64, 32'h8000_0000);
		send_request(ACT_SEARCH, 7'd0, 32'd12345);
		send_request(ACT_NOP, 7'd0, 32'h0000_0000);
		send_request(ACT_DELETE, 7'd64, 32'h0);
		send_request(ACT_DELETE, 7'd0, 32'h0);
		send_request(ACT_DELETE, 7'd1, 32'h0);
		send_request(ACT_INSERT, 7'd3, 32'h5555_5555);
		send_request(ACT_INSERT, 7'd1, 32'hAAAA_AAAA);
		send_request(ACT_SEARCH, 7'd5, 32'hAAAA_AAAA);
		send_request(ACT_DELETE, 7'd2, 32'h0);
		send_request(ACT_DELETE, 7'd64, 32'h0);
		send_request(ACT_DELETE, 7'd0, 32'h0);
		send_request(ACT_DELETE, 7'd0, 32'h0);
		send_request(ACT_DELETE, 7'd0, 32'h0);
		send_request(ACT_SEARCH, 7'd64, 32'hFFFF_FFFF);

		// Random segments: rotate the idle mode and alternate filling and draining
		// so the length sweeps from empty to full and back, with full inserts and
		// empty deletes along the way.
		for (seg = 0; seg < 8; seg++) begin
			case (seg % 4)
				0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
				1: begin snd_idle_pct = 76; rcv_stall_pct = 0;  end
				2: begin snd_idle_pct = 0;  rcv_stall_pct = 76; end
				default: begin snd_idle_pct = 14; rcv_stall_pct = 14; end
			endcase
			case (seg)
				0, 2, 4, 7: begin ins_pct = 80; del_pct = 8;  end
				1, 5:       begin ins_pct = 8;  del_pct = 80; end
				default:    begin ins_pct = 40; del_pct = 35; end
			endcase
			// Hold off the receiver while requests keep coming, so the engine backs up.
			if (seg == 0 || seg == 4)
				hold_requests++;
			for (n = 0; n < SEG_REQUESTS; n++)
				send_random_request(ins_pct, del_pct);
		end

		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_replies != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0)
			$display("ordered_list_engine_top_tb: PASS");
		else
			$display("ordered_list_engine_top_tb: FAIL");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ole_pkg.sv
rtl/ole_datapath.sv
rtl/ole_controller.sv
rtl/ordered_list_engine_top.sv
rtl/ole_checker.sv
sim/ordered_list_checker.sv
sim/ordered_list_engine_top_tb.sv
